// ----- design/ehd_pkg.sv -----
// ----------------------------------------------------------------------------
// ehd_pkg - shared types and constants of the holiday date calculator
// Word formats, range limits, holiday offsets and the month boundary table.
// ----------------------------------------------------------------------------
package ehd_pkg;

   localparam int YearW     = 14;
   localparam int HolW      = 3;
   localparam int BaseW     = 8;
   localparam int CmpStages = 7;
   localparam int DatStages = 4;

   localparam logic [YearW-1:0] YearMin = 14'd1583;
   localparam logic [YearW-1:0] YearMax = 14'd9999;

   // Holiday codes
   localparam logic [HolW-1:0] HolCarnStart = 3'd0;
   localparam logic [HolW-1:0] HolCarnEnd   = 3'd1;
   localparam logic [HolW-1:0] HolGoodFri   = 3'd2;
   localparam logic [HolW-1:0] HolEaster    = 3'd3;
   localparam logic [HolW-1:0] HolAscension = 3'd4;
   localparam logic [HolW-1:0] HolWhitsun   = 3'd5;

   typedef struct packed {
      logic [YearW-1:0] year;
      logic [HolW-1:0]  holiday;
   } req_type;

   typedef struct packed {
      logic [4:0] day_of_month;
      logic [3:0] month_number;
      logic       out_of_range;
   } rsp_type;

   // Easter base value plus what the date stages still need
   typedef struct packed {
      logic [BaseW-1:0] base;
      logic             leap;
      logic [HolW-1:0]  holiday;
      logic             oor;
   } easter_type;

   // Day offset from Easter Sunday, 9-bit two's complement
   function automatic logic [8:0] hol_offset(input logic [HolW-1:0] hol);
      logic [8:0] off;
      begin
         unique case (hol)
            HolCarnStart: off = -9'sd49;
            HolCarnEnd:   off = -9'sd46;
            HolGoodFri:   off = -9'sd2;
            HolEaster:    off = 9'd0;
            HolAscension: off = 9'd39;
            HolWhitsun:   off = 9'd49;
            default:      off = 9'd0;
         endcase
         return off;
      end
   endfunction

   // Days in months 1..m (m = 0 gives 0)
   function automatic logic [8:0] cum_end(input logic [3:0] m, input logic leap);
      logic [8:0] d;
      begin
         unique case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
         endcase
         if (leap && m >= 4'd2) begin
            d = d + 9'd1;
         end
         return d;
      end
   endfunction

endpackage

// ----- design/ehd_computus.sv -----
// ----------------------------------------------------------------------------
// ehd_computus - pipelined Meeus computus
// Seven stages from year to the Easter base value H + L - 7M + 114.
// ----------------------------------------------------------------------------
module ehd_computus
   import ehd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  req_type    in_word,
   output logic       out_valid,
   input  logic       out_stall,
   output easter_type out_word
);

   logic [CmpStages-1:0] valid_ff;
   logic [CmpStages-1:0] en;

   // stage 1
   logic [YearW-1:0] year1_ff;
   logic [7:0]       q100_1_ff;
   logic [9:0]       q19_1_ff;
   logic [HolW-1:0]  hol1_ff;
   logic             oor1_ff;
   logic [26:0]      p100_in;
   logic [28:0]      p19_in;
   // stage 2
   logic [4:0]       a2_ff;
   logic [7:0]       b2_ff;
   logic [6:0]       c2_ff;
   logic [HolW-1:0]  hol2_ff;
   logic             oor2_ff;
   logic [YearW-1:0] c_in;
   logic [YearW-1:0] a_in;
   // stage 3
   logic [4:0]       a3_ff;
   logic [7:0]       b3_ff;
   logic [5:0]       d3_ff;
   logic [1:0]       e3_ff;
   logic [4:0]       f3_ff;
   logic [4:0]       i3_ff;
   logic [1:0]       k3_ff;
   logic             leap3_ff;
   logic [HolW-1:0]  hol3_ff;
   logic             oor3_ff;
   logic [14:0]      pf_in;
   // stage 4
   logic [4:0]       a4_ff;
   logic [7:0]       g4_ff;
   logic [9:0]       p4_ff;
   logic [1:0]       e4_ff;
   logic [4:0]       i4_ff;
   logic [1:0]       k4_ff;
   logic             leap4_ff;
   logic [HolW-1:0]  hol4_ff;
   logic             oor4_ff;
   logic [8:0]       gs_in;
   logic [16:0]      pg_in;
   // stage 5
   logic [4:0]       a5_ff;
   logic [4:0]       h5_ff;
   logic [1:0]       e5_ff;
   logic [4:0]       i5_ff;
   logic [1:0]       k5_ff;
   logic             leap5_ff;
   logic [HolW-1:0]  hol5_ff;
   logic             oor5_ff;
   logic [9:0]       x_in;
   logic [19:0]      px_in;
   logic [9:0]       h_in;
   // stage 6
   logic [4:0]       a6_ff;
   logic [4:0]       h6_ff;
   logic [2:0]       l6_ff;
   logic             leap6_ff;
   logic [HolW-1:0]  hol6_ff;
   logic             oor6_ff;
   logic [7:0]       ys_in;
   logic [14:0]      py_in;
   logic [7:0]       l_in;
   // stage 7
   easter_type       out7_ff;
   logic [9:0]       mx_in;
   logic [BaseW-1:0] base_in;

   // A stage loads when it is empty or its content moves on
   always_comb begin
      en[CmpStages-1] = !valid_ff[CmpStages-1] || !out_stall;
      for (int s = CmpStages - 2; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   assign in_stall  = !en[0];
   assign out_valid = valid_ff[CmpStages-1];
   assign out_word  = out7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int s = 1; s < CmpStages; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // Reciprocal products for year / 100 and year / 19
   assign p100_in = 27'(in_word.year) * 27'd5243;
   assign p19_in  = 29'(in_word.year) * 29'd27595;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         year1_ff  <= in_word.year;
         q100_1_ff <= p100_in[26:19];
         q19_1_ff  <= p19_in[28:19];
         hol1_ff   <= in_word.holiday;
         oor1_ff   <= (in_word.year < YearMin) || (in_word.year > YearMax);
      end
   end

   assign c_in = year1_ff - YearW'(q100_1_ff * 14'd100);
   assign a_in = year1_ff - YearW'(q19_1_ff * 14'd19);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         a2_ff   <= a_in[4:0];
         b2_ff   <= q100_1_ff;
         c2_ff   <= c_in[6:0];
         hol2_ff <= hol1_ff;
         oor2_ff <= oor1_ff;
      end
   end

   // f = (b + 8) / 25
   assign pf_in = (15'(b2_ff) + 15'd8) * 15'd41;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         a3_ff    <= a2_ff;
         b3_ff    <= b2_ff;
         d3_ff    <= b2_ff[7:2];
         e3_ff    <= b2_ff[1:0];
         f3_ff    <= pf_in[14:10];
         i3_ff    <= c2_ff[6:2];
         k3_ff    <= c2_ff[1:0];
         leap3_ff <= (c2_ff == 7'd0) ? (b2_ff[1:0] == 2'd0) : (c2_ff[1:0] == 2'd0);
         hol3_ff  <= hol2_ff;
         oor3_ff  <= oor2_ff;
      end
   end

   // g = (b - f + 1) / 3
   assign gs_in = 9'(b3_ff) - 9'(f3_ff) + 9'd1;
   assign pg_in = 17'(gs_in) * 17'd171;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         a4_ff    <= a3_ff;
         g4_ff    <= pg_in[16:9];
         p4_ff    <= 10'(a3_ff) * 10'd19 + 10'(b3_ff) - 10'(d3_ff) + 10'd15;
         e4_ff    <= e3_ff;
         i4_ff    <= i3_ff;
         k4_ff    <= k3_ff;
         leap4_ff <= leap3_ff;
         hol4_ff  <= hol3_ff;
         oor4_ff  <= oor3_ff;
      end
   end

   // h = x mod 30
   assign x_in  = p4_ff - 10'(g4_ff);
   assign px_in = 20'(x_in) * 20'd547;
   assign h_in  = x_in - 10'(px_in[19:14]) * 10'd30;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         a5_ff    <= a4_ff;
         h5_ff    <= h_in[4:0];
         e5_ff    <= e4_ff;
         i5_ff    <= i4_ff;
         k5_ff    <= k4_ff;
         leap5_ff <= leap4_ff;
         hol5_ff  <= hol4_ff;
         oor5_ff  <= oor4_ff;
      end
   end

   // l = (32 + 2e + 2i - h - k) mod 7
   assign ys_in = 8'd32 + {5'd0, e5_ff, 1'b0} + {2'd0, i5_ff, 1'b0}
                  - 8'(h5_ff) - 8'(k5_ff);
   assign py_in = 15'(ys_in) * 15'd147;
   assign l_in  = ys_in - 8'(py_in[14:10]) * 8'd7;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         a6_ff    <= a5_ff;
         h6_ff    <= h5_ff;
         l6_ff    <= l_in[2:0];
         leap6_ff <= leap5_ff;
         hol6_ff  <= hol5_ff;
         oor6_ff  <= oor5_ff;
      end
   end

   // m = (a + 11h + 22l) / 451 is 0 or 1
   assign mx_in   = 10'(a6_ff) + 10'(h6_ff) * 10'd11 + 10'(l6_ff) * 10'd22;
   assign base_in = 8'(h6_ff) + 8'(l6_ff) + 8'd114 - ((mx_in >= 10'd451) ? 8'd7 : 8'd0);

   always_ff @(posedge clock) begin
      if (en[6]) begin
         out7_ff.base    <= base_in;
         out7_ff.leap    <= leap6_ff;
         out7_ff.holiday <= hol6_ff;
         out7_ff.oor     <= oor6_ff;
      end
   end

endmodule

// ----- design/easter_holiday_date_calc_top.sv -----
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while rsp is not stalled.
// Each of the 11 stages holds one word.
// A stall on rsp backs up only the stages that are full; bubbles close up.
// Reset (synchronous, active high) clears all stage valid bits; data regs keep.
// ----------------------------------------------------------------------------
// easter_holiday_date_calc_top - holiday date calculator
// Meeus computus, then day of year, holiday offset and conversion back to
// day and month.
// ----------------------------------------------------------------------------
module easter_holiday_date_calc_top
   import ehd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   // Computus front end hands over the Easter base value
   logic       cmp_valid;
   logic       cmp_stall;
   easter_type cmp_word;

   ehd_computus u_computus (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_word   (req_word),
      .out_valid (cmp_valid),
      .out_stall (cmp_stall),
      .out_word  (cmp_word)
   );

   logic [DatStages-1:0] valid_ff;
   logic [DatStages-1:0] en;

   // Stage D1: day of year of Easter Sunday
   logic [6:0]      doy1_ff;
   logic            leap1_ff;
   logic [HolW-1:0] hol1_ff;
   logic            oor1_ff;
   logic            em4_in;
   logic [7:0]      ed_in;
   logic [7:0]      doy_in;
   // Stage D2: day of year of the holiday
   logic [7:0]      tgt2_ff;
   logic            leap2_ff;
   logic            oor2_ff;
   logic [8:0]      tgt_in;
   // Stage D3: month found
   logic [7:0]      tgt3_ff;
   logic [3:0]      mon3_ff;
   logic            leap3_ff;
   logic            oor3_ff;
   logic [3:0]      mon_in;
   // Stage D4: output register
   rsp_type         rsp_ff;
   logic [8:0]      day_in;

   // Move a stage when it is empty or the next one takes its word
   always_comb begin
      en[DatStages-1] = !valid_ff[DatStages-1] || !rsp_stall;
      for (int s = DatStages - 2; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   assign cmp_stall = !en[0];
   assign rsp_valid = valid_ff[DatStages-1];
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= cmp_valid;
         end
         for (int s = 1; s < DatStages; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // Easter is in March (base 93..123) or April (base 124..154)
   assign em4_in = cmp_word.base >= 8'd124;
   assign ed_in  = cmp_word.base - (em4_in ? 8'd123 : 8'd92);
   // Add January, February and, for April, March
   assign doy_in = ed_in + 8'd59 + 8'(cmp_word.leap) + (em4_in ? 8'd31 : 8'd0);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         doy1_ff  <= doy_in[6:0];
         leap1_ff <= cmp_word.leap;
         hol1_ff  <= cmp_word.holiday;
         oor1_ff  <= cmp_word.oor;
      end
   end

   // Apply the holiday offset; the sum stays positive for valid years
   assign tgt_in = 9'(doy1_ff) + hol_offset(hol1_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         tgt2_ff  <= tgt_in[7:0];
         leap2_ff <= leap1_ff;
         oor2_ff  <= oor1_ff;
      end
   end

   // Month = 1 + number of month ends the day of year lies beyond
   always_comb begin
      mon_in = 4'd1;
      for (int m = 1; m < 12; m++) begin
         if (9'(tgt2_ff) > cum_end(4'(m), leap2_ff)) begin
            mon_in = mon_in + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         tgt3_ff  <= tgt2_ff;
         mon3_ff  <= mon_in;
         leap3_ff <= leap2_ff;
         oor3_ff  <= oor2_ff;
      end
   end

   // Drop the days of the preceding months
   assign day_in = 9'(tgt3_ff) - cum_end(mon3_ff - 4'd1, leap3_ff);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         rsp_ff.day_of_month <= oor3_ff ? 5'd0 : day_in[4:0];
         rsp_ff.month_number <= oor3_ff ? 4'd0 : mon3_ff;
         rsp_ff.out_of_range <= oor3_ff;
      end
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - holiday date calculator
// Sends year/holiday words through the valid/stall request channel and checks
// each rsp word against a local date calculation: Gregorian Easter first, then
// day of year, holiday shift and back to day and month. The sender runs in
// bursts and the receiver stalls in changing modes.
// ----------------------------------------------------------------------------
module testbench;
   import ehd_pkg::*;

   // Pipeline depth, taken from the package stage counts
   localparam int Latency   = CmpStages + DatStages;
   // Cycles without any accepted word before the run is abandoned
   localparam int IdleLimit = 3000;
   localparam int RandomQueries = 1450;

   // Holiday codes with no holiday behind them; the block treats them as Easter
   localparam logic [HolW-1:0] HolSpare6 = 3'd6;
   localparam logic [HolW-1:0] HolSpare7 = 3'd7;

   typedef enum logic [1:0] {
      StallNone,
      StallLight,
      StallHeavy,
      StallPattern
   } stall_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   // Dates still owed by the block, oldest first
   rsp_type        pending_dates[$];
   rsp_type        due_date;
   int             mismatches  = 0;
   int             idle_cycles = 0;
   int             burst_left  = 0;
   stall_mode_type stall_mode  = StallNone;
   int             stall_run   = 0;
   int             stall_phase = 0;

   easter_holiday_date_calc_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Date calculation
   // -------------------------------------------------------------------------

   function automatic bit is_gregorian_leap(input int yr);
      if (yr % 400 == 0) return 1'b1;
      if (yr % 100 == 0) return 1'b0;
      return (yr % 4) == 0;
   endfunction

   function automatic int month_length(input int yr, input int mon);
      int len;
      case (mon)
         2:             len = is_gregorian_leap(yr) ? 29 : 28;
         4, 6, 9, 11:   len = 30;
         default:       len = 31;
      endcase
      return len;
   endfunction

   // Meeus value: Easter month is this / 31, Easter day this % 31 + 1
   function automatic int meeus_base(input int yr);
      int golden, cent, yoc, cent_q, cent_r, corr_f, corr_g, epact, yoc_q, yoc_r;
      int wday, shift;
      golden = yr % 19;
      cent   = yr / 100;
      yoc    = yr % 100;
      cent_q = cent / 4;
      cent_r = cent % 4;
      corr_f = (cent + 8) / 25;
      corr_g = (cent - corr_f + 1) / 3;
      epact  = (19 * golden + cent - cent_q - corr_g + 15) % 30;
      yoc_q  = yoc / 4;
      yoc_r  = yoc % 4;
      wday   = (32 + 2 * cent_r + 2 * yoc_q - epact - yoc_r) % 7;
      shift  = (golden + 11 * epact + 22 * wday) / 451;
      return epact + wday + 114 - 7 * shift;
   endfunction

   function automatic int holiday_shift(input logic [HolW-1:0] hol);
      int days;
      case (hol)
         HolCarnStart: days = -49;
         HolCarnEnd:   days = -46;
         HolGoodFri:   days = -2;
         HolEaster:    days = 0;
         HolAscension: days = 39;
         HolWhitsun:   days = 49;
         default:      days = 0;
      endcase
      return days;
   endfunction

   function automatic rsp_type holiday_date(input req_type query);
      rsp_type date;
      int      yr, base, easter_mon, day_num, mon;
      yr   = int'(query.year);
      date = '0;
      if (query.year < YearMin || query.year > YearMax) begin
         date.out_of_range = 1'b1;
         return date;
      end
      base       = meeus_base(yr);
      easter_mon = base / 31;
      day_num    = base % 31 + 1;
      for (int m = 1; m < easter_mon; m++) begin
         day_num += month_length(yr, m);
      end
      day_num += holiday_shift(query.holiday);
      mon = 1;
      while (mon < 12 && day_num > month_length(yr, mon)) begin
         day_num -= month_length(yr, mon);
         mon++;
      end
      date.day_of_month = day_num[4:0];
      date.month_number = mon[3:0];
      return date;
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Hold one word on the request channel until it is taken. Between bursts,
   // drop valid for a random gap; a zero gap gives back-to-back bursts.
   task automatic send_query(input logic [YearW-1:0] yr, input logic [HolW-1:0] hol);
      req_type query;
      int      gap;
      query.year    = yr;
      query.holiday = hol;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word  <= query;
      // Advance until an edge sees valid high and stall low
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_dates.push_back(holiday_date(query));
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Years on and just past both ends of the valid range, and the field limits
   task automatic test_year_limits();
      send_query('0, HolEaster);
      send_query(YearMin - 14'd1, HolCarnStart);
      send_query(YearMin, HolCarnStart);
      send_query(YearMax, HolWhitsun);
      send_query(YearMax + 14'd1, HolEaster);
      send_query('1, HolSpare7);
   endtask

   // Every holiday code of one year, the two unused codes included
   task automatic test_all_holidays();
      send_query(14'd2024, HolCarnStart);
      send_query(14'd2024, HolCarnEnd);
      send_query(14'd2024, HolGoodFri);
      send_query(14'd2024, HolEaster);
      send_query(14'd2024, HolAscension);
      send_query(14'd2024, HolWhitsun);
      send_query(14'd2024, HolSpare6);
      send_query(14'd2024, HolSpare7);
   endtask

   // Century years, leap and not, queried for carnival start or end
   task automatic test_leap_rules();
      send_query(14'd1900, HolCarnStart);
      send_query(14'd2000, HolCarnStart);
      send_query(14'd2100, HolCarnEnd);
      send_query(14'd2400, HolCarnStart);
   endtask

   // Earliest and latest Easter, carrying the shifts to 1 February and 13 June
   task automatic test_extreme_easter();
      send_query(14'd1818, HolEaster);
      send_query(14'd2285, HolCarnStart);
      send_query(14'd1943, HolEaster);
      send_query(14'd1943, HolWhitsun);
   endtask

   // Mostly valid years, with a share out of range over the whole field
   task automatic test_random_queries();
      logic [YearW-1:0] yr;
      for (int n = 0; n < RandomQueries; n++) begin
         case ($urandom_range(0, 19))
            0:       yr = YearW'($urandom_range(0, int'(YearMin) - 1));
            1:       yr = YearW'($urandom_range(int'(YearMax) + 1, (1 << YearW) - 1));
            2:       yr = YearW'($urandom_range(0, (1 << YearW) - 1));
            default: yr = YearW'($urandom_range(int'(YearMin), int'(YearMax)));
         endcase
         send_query(yr, HolW'($urandom_range(0, (1 << HolW) - 1)));
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   // Stall in modes that change after a random run: none, light, heavy,
   // and a fixed on/off pattern
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_run  <= $urandom_range(8, 60);
      end else begin
         stall_run <= stall_run - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         StallNone:  rsp_stall <= 1'b0;
         StallLight: rsp_stall <= ($urandom_range(0, 3) == 0);
         StallHeavy: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:    rsp_stall <= (stall_phase % 7) < 3;
      endcase
   end

   // Compare every taken rsp word with the oldest owed date
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dates.size() == 0) begin
            $display("%0t: rsp word %h arrived with no date owed", $time, rsp_word);
            mismatches++;
         end else begin
            due_date = pending_dates.pop_front();
            if (rsp_word.day_of_month !== due_date.day_of_month) begin
               $display("%0t: day_of_month expected %0d actual %0d", $time,
                        due_date.day_of_month, rsp_word.day_of_month);
               mismatches++;
            end
            if (rsp_word.month_number !== due_date.month_number) begin
               $display("%0t: month_number expected %0d actual %0d", $time,
                        due_date.month_number, rsp_word.month_number);
               mismatches++;
            end
            if (rsp_word.out_of_range !== due_date.out_of_range) begin
               $display("%0t: out_of_range expected %0b actual %0b", $time,
                        due_date.out_of_range, rsp_word.out_of_range);
               mismatches++;
            end
         end
      end
   end

   // Abandon the run once neither channel has moved a word for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_year_limits();
      test_all_holidays();
      test_leap_rules();
      test_extreme_easter();
      test_random_queries();
      req_valid <= 1'b0;

      // Drain: wait for every owed date, then watch for strays
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (2 * Latency) @(posedge clock);

      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ----- easter_holiday_date_calc_top.f -----
design/ehd_pkg.sv
design/ehd_computus.sv
design/easter_holiday_date_calc_top.sv
sim/testbench.sv
